// File: rtl/lmfr_pkg.sv
// ----------------------------------------------------------------------------
// lmfr_pkg: shared types and constants for the link monitor frame receiver
// Holds the command format passed from the front end to the back end,
// request and result codes, and the configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package lmfr_pkg;

   // Request kinds
   localparam logic REQ_TICK = 1'b0;
   localparam logic REQ_BYTE = 1'b1;

   // Configuration register indexes
   localparam logic REG_HEADER = 1'b0;
   localparam logic REG_LIMIT  = 1'b1;

   // Reset values of the configuration registers
   localparam logic [7:0] HEADER_RESET = 8'h69;
   localparam logic [7:0] LIMIT_RESET  = 8'd5;

   // Result event kinds
   localparam logic [1:0] KIND_FRAME_BYTE = 2'd0;
   localparam logic [1:0] KIND_CKSUM_ERR  = 2'd1;
   localparam logic [1:0] KIND_LINK_LOST  = 2'd2;
   localparam logic [1:0] KIND_CONNECTED  = 2'd3;

   // Width of the byte index result field
   localparam int IDX_BITS = 6;

   // Command queue between front and back end
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef enum logic [2:0] {
      OP_STORE,   // write one frame byte into the store
      OP_RUN,     // write the checksum byte, then emit the stored frame
      OP_CKERR,   // report a checksum mismatch
      OP_LOST,    // report link lost
      OP_CONN     // report link connected
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type          op;
      logic [7:0]          data;
      logic [IDX_BITS-1:0] idx;
      logic [7:0]          sum;
   } cmd_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_READ,
      BK_SEND
   } back_state_type;

endpackage

`default_nettype wire

// File: rtl/link_monitor_frame_receiver.sv
// Throughput: one transaction per cycle while the 4-entry command queue has room;
// a good frame replays its FRAME_BYTES bytes one at a time, each as a store read then a send.
// Replay holds the back end, so the queue fills and stalls input after 4 commands.
// Reset: synchronous, active high; clears link state, counters, queue and output valid.
// The frame store needs no clearing; only bytes written in the current frame are read.
// ----------------------------------------------------------------------------
// link_monitor_frame_receiver: link monitor and status frame receiver
// Tracks radio lock from periodic samples and collects XOR-checked frames
// from a serial byte stream, reporting link events and verified frames.
// ----------------------------------------------------------------------------
`default_nettype none

module link_monitor_frame_receiver #(
   parameter int FRAME_BYTES = 16
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         csr_we,
   input  wire         csr_index,
   input  wire  [7:0]  csr_data,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire         req_type,
   input  wire         req_lock_level,
   input  wire  [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [1:0]  rsp_event_kind,
   output logic [7:0]  rsp_data_byte,
   output logic [5:0]  rsp_byte_index,
   output logic [7:0]  rsp_computed_sum,
   output logic        rsp_last_in_run
);

   logic               cmd_push;
   lmfr_pkg::cmd_type  cmd_in;
   logic               q_full;
   logic               q_valid;
   lmfr_pkg::cmd_type  q_data;
   logic               q_pop;

   lmfr_front #(
      .FRAME_BYTES(FRAME_BYTES)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_lock_level (req_lock_level),
      .req_rx_byte    (req_rx_byte),
      .q_full         (q_full),
      .cmd_push       (cmd_push),
      .cmd_data       (cmd_in)
   );

   lmfr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in),
      .full      (q_full),
      .pop       (q_pop),
      .out_valid (q_valid),
      .out_data  (q_data)
   );

   lmfr_back #(
      .FRAME_BYTES(FRAME_BYTES)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_valid        (q_valid),
      .cmd_data         (q_data),
      .cmd_pop          (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_computed_sum (rsp_computed_sum),
      .rsp_last_in_run  (rsp_last_in_run)
   );

endmodule

`default_nettype wire

// File: rtl/lmfr_front.sv
// ----------------------------------------------------------------------------
// lmfr_front: transaction classifier and link/frame tracker
// Holds configuration, link state, loss counter, frame position and the
// running XOR; turns each accepted transaction into at most one command.
// ----------------------------------------------------------------------------
`default_nettype none

module lmfr_front #(
   parameter int FRAME_BYTES = 16
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   csr_we,
   input  wire                   csr_index,
   input  wire [7:0]             csr_data,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  wire                   req_type,
   input  wire                   req_lock_level,
   input  wire [7:0]             req_rx_byte,
   input  wire                   q_full,
   output logic                  cmd_push,
   output lmfr_pkg::cmd_type     cmd_data
);

   localparam int IDX_W = $clog2(FRAME_BYTES);
   localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(FRAME_BYTES - 1);

   logic [7:0]       header_ff;
   logic [7:0]       limit_ff;
   logic             link_down_ff, link_down_in;
   logic [7:0]       low_cnt_ff, low_cnt_in;
   logic [IDX_W-1:0] pos_ff, pos_in;
   logic [7:0]       xor_ff, xor_in;
   logic [7:0]       low_cnt_inc;
   logic             accept;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff <= lmfr_pkg::HEADER_RESET;
         limit_ff  <= lmfr_pkg::LIMIT_RESET;
      end else if (csr_we) begin
         if (csr_index == lmfr_pkg::REG_HEADER) begin
            header_ff <= csr_data;
         end else begin
            limit_ff <= csr_data;
         end
      end
   end

   // Accept whenever the command queue has room
   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   // Saturating increment of the low sample count
   assign low_cnt_inc = (low_cnt_ff == 8'hFF) ? low_cnt_ff : low_cnt_ff + 8'd1;

   // Classify the transaction and update link and frame state
   always_comb begin
      link_down_in  = link_down_ff;
      low_cnt_in    = low_cnt_ff;
      pos_in        = pos_ff;
      xor_in        = xor_ff;
      cmd_push      = 1'b0;
      cmd_data.op   = lmfr_pkg::OP_STORE;
      cmd_data.data = req_rx_byte;
      cmd_data.idx  = lmfr_pkg::IDX_BITS'(pos_ff);
      cmd_data.sum  = xor_ff;
      if (accept) begin
         if (req_type == lmfr_pkg::REQ_TICK) begin
            if (!req_lock_level) begin
               if (!link_down_ff) begin
                  low_cnt_in = low_cnt_inc;
                  if (low_cnt_inc >= limit_ff) begin
                     link_down_in = 1'b1;
                     pos_in       = '0;
                     xor_in       = 8'd0;
                     cmd_push     = 1'b1;
                     cmd_data.op  = lmfr_pkg::OP_LOST;
                  end
               end
            end else if (link_down_ff) begin
               low_cnt_in   = 8'd0;
               link_down_in = 1'b0;
               cmd_push     = 1'b1;
               cmd_data.op  = lmfr_pkg::OP_CONN;
            end
         end else if (!link_down_ff) begin
            if (pos_ff == '0) begin
               // hunt for the header byte
               if (req_rx_byte == header_ff) begin
                  cmd_push = 1'b1;
                  xor_in   = req_rx_byte;
                  pos_in   = IDX_W'(1);
               end
            end else if (pos_ff == LAST_POS) begin
               // checksum byte closes the frame
               cmd_push    = 1'b1;
               cmd_data.op = (xor_ff == req_rx_byte) ? lmfr_pkg::OP_RUN
                                                     : lmfr_pkg::OP_CKERR;
               pos_in      = '0;
               xor_in      = 8'd0;
            end else begin
               cmd_push = 1'b1;
               xor_in   = xor_ff ^ req_rx_byte;
               pos_in   = pos_ff + IDX_W'(1);
            end
         end
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         link_down_ff <= 1'b0;
         low_cnt_ff   <= 8'd0;
         pos_ff       <= '0;
         xor_ff       <= 8'd0;
      end else begin
         link_down_ff <= link_down_in;
         low_cnt_ff   <= low_cnt_in;
         pos_ff       <= pos_in;
         xor_ff       <= xor_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/lmfr_queue.sv
// ----------------------------------------------------------------------------
// lmfr_queue: short command queue
// Decouples the front end from the back end so each side stalls on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module lmfr_queue (
   input  wire                clock,
   input  wire                reset,
   input  wire                push,
   input  lmfr_pkg::cmd_type  push_data,
   output logic               full,
   input  wire                pop,
   output logic               out_valid,
   output lmfr_pkg::cmd_type  out_data
);

   localparam logic [lmfr_pkg::QPTR_W:0] DEPTH = (lmfr_pkg::QPTR_W + 1)'(lmfr_pkg::QUEUE_DEPTH);

   lmfr_pkg::cmd_type               q_ff [lmfr_pkg::QUEUE_DEPTH];
   logic [lmfr_pkg::QPTR_W-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [lmfr_pkg::QPTR_W:0]       count_ff;
   logic                            do_push, do_pop;

   assign full      = (count_ff == DEPTH);
   assign out_valid = (count_ff != '0);
   assign out_data  = q_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && out_valid;

   // Store pushed commands
   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + lmfr_pkg::QPTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + lmfr_pkg::QPTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + (lmfr_pkg::QPTR_W + 1)'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - (lmfr_pkg::QPTR_W + 1)'(1);
         end
      end
   end

endmodule

`default_nettype wire

// File: rtl/lmfr_back.sv
// ----------------------------------------------------------------------------
// lmfr_back: command executor and result register
// Owns the frame store, writes frame bytes, emits events and replays a
// verified frame one byte at a time through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module lmfr_back #(
   parameter int FRAME_BYTES = 16
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          cmd_valid,
   input  lmfr_pkg::cmd_type            cmd_data,
   output logic                         cmd_pop,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output logic [1:0]                   rsp_event_kind,
   output logic [7:0]                   rsp_data_byte,
   output logic [lmfr_pkg::IDX_BITS-1:0] rsp_byte_index,
   output logic [7:0]                   rsp_computed_sum,
   output logic                         rsp_last_in_run
);

   localparam int IDX_W = $clog2(FRAME_BYTES);
   localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(FRAME_BYTES - 1);

   logic [7:0]                     mem [FRAME_BYTES];
   logic [7:0]                     rd_data_ff;
   logic                           mem_we;

   lmfr_pkg::back_state_type       state_ff, state_in;
   logic [IDX_W-1:0]               cnt_ff, cnt_in;
   logic [7:0]                     sum_ff, sum_in;

   logic                           valid_ff, valid_in;
   logic [1:0]                     kind_ff, kind_in;
   logic [7:0]                     data_ff, data_in;
   logic [lmfr_pkg::IDX_BITS-1:0]  idx_ff, idx_in;
   logic [7:0]                     osum_ff, osum_in;
   logic                           last_ff, last_in;
   logic                           load;
   logic                           out_free;

   assign out_free = !valid_ff || rsp_ready;

   // Frame store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[cmd_data.idx[IDX_W-1:0]] <= cmd_data.data;
      end
      rd_data_ff <= mem[cnt_ff];
   end

   // Sequence commands and build results
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      sum_in   = sum_ff;
      cmd_pop  = 1'b0;
      mem_we   = 1'b0;
      load     = 1'b0;
      kind_in  = lmfr_pkg::KIND_FRAME_BYTE;
      data_in  = 8'd0;
      idx_in   = '0;
      osum_in  = 8'd0;
      last_in  = 1'b1;
      unique case (state_ff)
         lmfr_pkg::BK_IDLE: begin
            if (cmd_valid) begin
               unique case (cmd_data.op)
                  lmfr_pkg::OP_STORE: begin
                     mem_we  = 1'b1;
                     cmd_pop = 1'b1;
                  end
                  lmfr_pkg::OP_RUN: begin
                     mem_we   = 1'b1;
                     cmd_pop  = 1'b1;
                     sum_in   = cmd_data.sum;
                     cnt_in   = '0;
                     state_in = lmfr_pkg::BK_READ;
                  end
                  lmfr_pkg::OP_CKERR: begin
                     if (out_free) begin
                        load    = 1'b1;
                        cmd_pop = 1'b1;
                        kind_in = lmfr_pkg::KIND_CKSUM_ERR;
                        data_in = cmd_data.data;
                        idx_in  = cmd_data.idx;
                        osum_in = cmd_data.sum;
                     end
                  end
                  lmfr_pkg::OP_LOST: begin
                     if (out_free) begin
                        load    = 1'b1;
                        cmd_pop = 1'b1;
                        kind_in = lmfr_pkg::KIND_LINK_LOST;
                     end
                  end
                  lmfr_pkg::OP_CONN: begin
                     if (out_free) begin
                        load    = 1'b1;
                        cmd_pop = 1'b1;
                        kind_in = lmfr_pkg::KIND_CONNECTED;
                     end
                  end
                  default: begin
                     // drop codes that carry no meaning
                     cmd_pop = 1'b1;
                  end
               endcase
            end
         end
         lmfr_pkg::BK_READ: begin
            // read data lands in rd_data_ff at the next edge
            state_in = lmfr_pkg::BK_SEND;
         end
         lmfr_pkg::BK_SEND: begin
            if (out_free) begin
               load    = 1'b1;
               kind_in = lmfr_pkg::KIND_FRAME_BYTE;
               data_in = rd_data_ff;
               idx_in  = lmfr_pkg::IDX_BITS'(cnt_ff);
               osum_in = sum_ff;
               last_in = (cnt_ff == LAST_POS);
               if (cnt_ff == LAST_POS) begin
                  state_in = lmfr_pkg::BK_IDLE;
               end else begin
                  cnt_in   = cnt_ff + IDX_W'(1);
                  state_in = lmfr_pkg::BK_READ;
               end
            end
         end
         default: begin
            state_in = lmfr_pkg::BK_IDLE;
         end
      endcase
      valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : valid_ff);
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lmfr_pkg::BK_IDLE;
         cnt_ff   <= '0;
         sum_ff   <= 8'd0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         sum_ff   <= sum_in;
         valid_ff <= valid_in;
      end
   end

   // Result payload register
   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff <= kind_in;
         data_ff <= data_in;
         idx_ff  <= idx_in;
         osum_ff <= osum_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_event_kind   = kind_ff;
   assign rsp_data_byte    = data_ff;
   assign rsp_byte_index   = idx_ff;
   assign rsp_computed_sum = osum_ff;
   assign rsp_last_in_run  = last_ff;

endmodule

`default_nettype wire
